>>> rtl/cpd_pkg.sv
// cpd_pkg: shared types, widths, register indexes and fault codes for the
// complementary pwm generator; no dependencies
`timescale 1ns / 1ps

package cpd_pkg;

    // fixed field widths
    localparam int CLOCK_W     = 28;
    localparam int FREQ_W      = 27;
    localparam int LEVEL_W     = 8;
    localparam int FAULT_W     = 2;
    localparam int COUNT_OUT_W = 16;

    // configuration port
    localparam int CFG_DATA_W = 28;
    localparam int CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] REG_CLOCK_HZ       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PWM_FREQ_HZ    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_LEVEL     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEADTIME_LEVEL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_ENABLE   = 3'd4;

    // register reset values
    localparam logic [CLOCK_W-1:0] CLOCK_HZ_RST    = 28'd42000000;
    localparam logic [FREQ_W-1:0]  PWM_FREQ_HZ_RST = 27'd20000;
    localparam logic [LEVEL_W-1:0] DUTY_RST        = 8'd0;
    localparam logic [LEVEL_W-1:0] DEADTIME_RST    = 8'd1;

    // full scale of duty and dead gap levels
    localparam int LEVEL_MAX = 255;

    // serial arithmetic datapath width: holds level * period
    localparam int DIV_W      = 36;
    localparam int DIV_CNT_W  = $clog2(DIV_W + 1);
    localparam int MUL_CNT_W  = $clog2(LEVEL_W + 1);

    // default counter width
    localparam int COUNTER_BITS_DEF = 16;

    // fault codes
    localparam logic [FAULT_W-1:0] FAULT_NONE = 2'd0;
    localparam logic [FAULT_W-1:0] FAULT_FREQ = 2'd1;
    localparam logic [FAULT_W-1:0] FAULT_SUM  = 2'd2;
    localparam logic [FAULT_W-1:0] FAULT_GAP  = 2'd3;

    typedef struct packed {
        logic [CLOCK_W-1:0] clock_hz;
        logic [FREQ_W-1:0]  pwm_freq_hz;
        logic [LEVEL_W-1:0] duty_level;
        logic [LEVEL_W-1:0] deadtime_level;
        logic               drive_enable;
    } cfg_t;

    typedef enum logic [3:0] {
        T_IDLE,
        T_DIV_Q,
        T_MUL_HI,
        T_DIV_HI,
        T_MUL_LO,
        T_DIV_LO,
        T_DIV_NF,
        T_DONE
    } timing_state_t;

    typedef enum logic {
        S_RUN,
        S_RESTART
    } top_state_t;

endpackage

>>> rtl/cpd_div.sv
// cpd_div: restoring divider, one quotient bit per cycle
// depends on cpd_pkg
`timescale 1ns / 1ps

module cpd_div
    import cpd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DIV_W-1:0] divisor,
    output logic             done,
    output logic [DIV_W-1:0] quotient
);

    logic [DIV_W-1:0]     rem_reg, rem_next;
    logic [DIV_W-1:0]     quo_reg, quo_next;
    logic [DIV_W-1:0]     dsr_reg, dsr_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 done_reg, done_next;

    logic [DIV_W:0] rem_shift;
    logic [DIV_W:0] diff;
    logic           ge;

    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[DIV_W-1]};
        diff      = rem_shift - {1'b0, dsr_reg};
        ge        = (rem_shift >= {1'b0, dsr_reg});

        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;

        if (start)
        begin
            rem_next = '0;
            quo_next = dividend;
            dsr_next = divisor;
            cnt_next = DIV_CNT_W'(DIV_W);
        end
        else if (cnt_reg != '0)
        begin
            rem_next  = ge ? diff[DIV_W-1:0] : rem_shift[DIV_W-1:0];
            quo_next  = {quo_reg[DIV_W-2:0], ge};
            cnt_next  = cnt_reg - DIV_CNT_W'(1);
            done_next = (cnt_reg == DIV_CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> rtl/cpd_mul.sv
// cpd_mul: shift-add multiplier, one bit of the 8-bit level per cycle
// depends on cpd_pkg
`timescale 1ns / 1ps

module cpd_mul
    import cpd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [LEVEL_W-1:0] level,
    input  logic [DIV_W-1:0]   operand,
    output logic               done,
    output logic [DIV_W-1:0]   product
);

    logic [DIV_W-1:0]     acc_reg, acc_next;
    logic [LEVEL_W-1:0]   mpl_reg, mpl_next;
    logic [DIV_W-1:0]     mcd_reg, mcd_next;
    logic [MUL_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 done_reg, done_next;

    always_comb
    begin
        acc_next  = acc_reg;
        mpl_next  = mpl_reg;
        mcd_next  = mcd_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;

        if (start)
        begin
            acc_next = '0;
            mpl_next = level;
            mcd_next = operand;
            cnt_next = MUL_CNT_W'(LEVEL_W);
        end
        else if (cnt_reg != '0)
        begin
            // msb first: double the partial sum, add the operand on a one
            acc_next  = {acc_reg[DIV_W-2:0], 1'b0} + (mpl_reg[LEVEL_W-1] ? mcd_reg : '0);
            mpl_next  = {mpl_reg[LEVEL_W-2:0], 1'b0};
            cnt_next  = cnt_reg - MUL_CNT_W'(1);
            done_next = (cnt_reg == MUL_CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        mpl_reg <= mpl_next;
        mcd_reg <= mcd_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

>>> rtl/cpd_timing.sv
// cpd_timing: restart sequencer; works out period, compares, next frequency
// and fault code with the serial divider and multiplier; depends on cpd_pkg
`timescale 1ns / 1ps

module cpd_timing
    import cpd_pkg::*;
#(
    parameter int COUNTER_BITS = COUNTER_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic                    ack,
    input  cfg_t                    cfg,
    output logic                    done,
    output logic [FAULT_W-1:0]      fault,
    output logic [COUNTER_BITS-1:0] period,
    output logic [COUNTER_BITS-1:0] comp_hi,
    output logic [COUNTER_BITS-1:0] comp_lo,
    output logic [FREQ_W-1:0]       next_freq
);

    timing_state_t state_reg, state_next;

    logic [DIV_W-1:0]   p_reg, p_next;
    logic [DIV_W-1:0]   hi_reg, hi_next;
    logic [DIV_W-1:0]   lo_reg, lo_next;
    logic [FAULT_W-1:0] fault_reg, fault_next;
    logic [FREQ_W-1:0]  nf_reg, nf_next;

    logic               div_start, div_done;
    logic [DIV_W-1:0]   div_dividend, div_divisor, div_quo;
    logic               mul_start, mul_done;
    logic [LEVEL_W-1:0] mul_level;
    logic [DIV_W-1:0]   mul_operand, mul_prod;

    logic [DIV_W-1:0]   clock_w, freq2_w, per2_w;
    logic [DIV_W-1:0]   p_calc, hi_calc, lo_calc;
    logic [LEVEL_W:0]   lev_sum;
    logic               ok;

    cpd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    cpd_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .level   (mul_level),
        .operand (mul_operand),
        .done    (mul_done),
        .product (mul_prod)
    );

    assign clock_w = DIV_W'(cfg.clock_hz);
    assign freq2_w = DIV_W'({cfg.pwm_freq_hz, 1'b0});
    assign per2_w  = {p_reg[DIV_W-2:0], 1'b0};
    assign p_calc  = div_quo - DIV_W'(1);
    assign hi_calc = div_quo + DIV_W'(1);
    assign lo_calc = hi_reg + div_quo;
    assign lev_sum = {1'b0, cfg.duty_level} + {1'b0, cfg.deadtime_level};

    always_comb
    begin
        state_next   = state_reg;
        p_next       = p_reg;
        hi_next      = hi_reg;
        lo_next      = lo_reg;
        fault_next   = fault_reg;
        nf_next      = nf_reg;
        div_start    = 1'b0;
        div_dividend = clock_w;
        div_divisor  = freq2_w;
        mul_start    = 1'b0;
        mul_level    = cfg.duty_level;
        mul_operand  = p_reg;
        done         = 1'b0;

        unique case (state_reg)
            T_IDLE:
            begin
                if (start)
                begin
                    fault_next = FAULT_NONE;
                    nf_next    = '0;
                    if (cfg.pwm_freq_hz == '0)
                    begin
                        fault_next = FAULT_FREQ;
                        state_next = T_DONE;
                    end
                    else
                    begin
                        // clock / (2 * freq)
                        div_start  = 1'b1;
                        state_next = T_DIV_Q;
                    end
                end
            end

            T_DIV_Q:
            begin
                if (div_done)
                begin
                    if (div_quo == '0 || (p_calc >> COUNTER_BITS) != '0)
                    begin
                        fault_next = FAULT_FREQ;
                        state_next = T_DONE;
                    end
                    else
                    begin
                        p_next      = p_calc;
                        mul_start   = 1'b1;
                        mul_operand = p_calc;
                        state_next  = T_MUL_HI;
                    end
                end
            end

            T_MUL_HI:
            begin
                if (mul_done)
                begin
                    div_start    = 1'b1;
                    div_dividend = mul_prod;
                    div_divisor  = DIV_W'(LEVEL_MAX);
                    state_next   = T_DIV_HI;
                end
            end

            T_DIV_HI:
            begin
                if (div_done)
                begin
                    hi_next    = hi_calc;
                    mul_start  = 1'b1;
                    mul_level  = cfg.deadtime_level;
                    state_next = T_MUL_LO;
                end
            end

            T_MUL_LO:
            begin
                if (mul_done)
                begin
                    div_start    = 1'b1;
                    div_dividend = mul_prod;
                    div_divisor  = DIV_W'(LEVEL_MAX);
                    state_next   = T_DIV_LO;
                end
            end

            T_DIV_LO:
            begin
                if (div_done)
                begin
                    state_next = T_DONE;
                    if ((hi_reg >> COUNTER_BITS) != '0 || (lo_calc >> COUNTER_BITS) != '0)
                    begin
                        fault_next = FAULT_FREQ;
                    end
                    else if (lev_sum > (LEVEL_W + 1)'(LEVEL_MAX))
                    begin
                        fault_next = FAULT_SUM;
                    end
                    else if (div_quo == '0)
                    begin
                        // low compare does not clear the high compare
                        fault_next = FAULT_GAP;
                    end
                    else
                    begin
                        lo_next = lo_calc;
                        if (p_reg != '0)
                        begin
                            // clock / (2 * period)
                            div_start   = 1'b1;
                            div_divisor = per2_w;
                            state_next  = T_DIV_NF;
                        end
                    end
                end
            end

            T_DIV_NF:
            begin
                if (div_done)
                begin
                    nf_next    = div_quo[FREQ_W-1:0];
                    state_next = T_DONE;
                end
            end

            T_DONE:
            begin
                done = 1'b1;
                if (ack)
                begin
                    state_next = T_IDLE;
                end
            end

            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= T_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg     <= p_next;
        hi_reg    <= hi_next;
        lo_reg    <= lo_next;
        fault_reg <= fault_next;
        nf_reg    <= nf_next;
    end

    // a fault zeroes the whole timing set
    assign ok        = (fault_reg == FAULT_NONE);
    assign fault     = fault_reg;
    assign period    = ok ? p_reg[COUNTER_BITS-1:0]  : '0;
    assign comp_hi   = ok ? hi_reg[COUNTER_BITS-1:0] : '0;
    assign comp_lo   = ok ? lo_reg[COUNTER_BITS-1:0] : '0;
    assign next_freq = ok ? nf_reg : '0;

endmodule

>>> rtl/complementary_pwm_deadtime.sv
// complementary_pwm_deadtime: top level of the center-aligned half-bridge pwm
// with dead gap; depends on cpd_pkg, cpd_timing (cpd_div, cpd_mul)
`timescale 1ns / 1ps

// Each input item is one timer tick and yields one result item describing the
// counter and switch drives after that tick. A plain tick (restart = 0) goes
// straight into the output register, so ticks stream at one item per clock
// while the output side keeps up; a new tick can enter in the same cycle the
// previous result leaves, and while a result waits under out_stall, in_stall
// is high. A restart tick recomputes period, both compares and the next
// frequency from the configuration registers; this runs through a bit-serial
// restoring divider (36 steps per quotient, up to four quotients) and an
// 8-step shift-add multiplier (two products), so a restart item's result is
// loaded into the output register once that sequence ends or a fault cuts it
// short and the output register is free to take it; in_stall is high
// throughout. Configuration writes (clock, frequency, duty, dead gap) are
// used at the next restart; drive_enable acts on the next tick. Any fault
// forces the high side off and the low side on and parks the counter at zero.

module complementary_pwm_deadtime
    import cpd_pkg::*;
#(
    parameter int COUNTER_BITS = COUNTER_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    // configuration write port
    input  logic                   cfg_write_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,

    // tick channel
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   restart,

    // result channel
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   high_drive,
    output logic                   low_drive,
    output logic [COUNT_OUT_W-1:0] count_value,
    output logic                   counting_down,
    output logic [FAULT_W-1:0]     fault_code,
    output logic [FREQ_W-1:0]      next_frequency_hz
);

    localparam int CW_W = COUNTER_BITS + COUNT_OUT_W;

    // configuration registers
    cfg_t cfg_reg;

    // control
    top_state_t state_reg, state_next;

    // counter and active timing set
    logic [COUNTER_BITS-1:0] cnt_reg, cnt_next;
    logic                    dir_reg, dir_next;
    logic [COUNTER_BITS-1:0] per_reg, per_next;
    logic [COUNTER_BITS-1:0] chi_reg, chi_next;
    logic [COUNTER_BITS-1:0] clo_reg, clo_next;
    logic [FAULT_W-1:0]      fault_reg, fault_next;
    logic [FREQ_W-1:0]       nf_reg, nf_next;

    // output register
    logic                   ovalid_reg, ovalid_next;
    logic                   hd_reg, hd_next;
    logic                   ld_reg, ld_next;
    logic [COUNT_OUT_W-1:0] cv_reg, cv_next;
    logic                   cd_reg, cd_next;
    logic [FAULT_W-1:0]     fc_reg, fc_next;
    logic [FREQ_W-1:0]      nfo_reg, nfo_next;

    // timing unit
    logic                    t_start, t_ack, t_done;
    logic [FAULT_W-1:0]      t_fault;
    logic [COUNTER_BITS-1:0] t_period, t_hi, t_lo;
    logic [FREQ_W-1:0]       t_nf;

    logic                    accept, out_free, load, run;
    logic [COUNTER_BITS-1:0] cnt_adv;
    logic                    dir_adv;
    logic [CW_W-1:0]         count_wide;

    cpd_timing #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_timing (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (t_start),
        .ack       (t_ack),
        .cfg       (cfg_reg),
        .done      (t_done),
        .fault     (t_fault),
        .period    (t_period),
        .comp_hi   (t_hi),
        .comp_lo   (t_lo),
        .next_freq (t_nf)
    );

    // register writes; unknown indexes fall through
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.clock_hz       <= CLOCK_HZ_RST;
            cfg_reg.pwm_freq_hz    <= PWM_FREQ_HZ_RST;
            cfg_reg.duty_level     <= DUTY_RST;
            cfg_reg.deadtime_level <= DEADTIME_RST;
            cfg_reg.drive_enable   <= 1'b0;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                REG_CLOCK_HZ:       cfg_reg.clock_hz       <= cfg_data[CLOCK_W-1:0];
                REG_PWM_FREQ_HZ:    cfg_reg.pwm_freq_hz    <= cfg_data[FREQ_W-1:0];
                REG_DUTY_LEVEL:     cfg_reg.duty_level     <= cfg_data[LEVEL_W-1:0];
                REG_DEADTIME_LEVEL: cfg_reg.deadtime_level <= cfg_data[LEVEL_W-1:0];
                REG_DRIVE_ENABLE:   cfg_reg.drive_enable   <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    // counter step for a plain tick
    always_comb
    begin
        cnt_adv = cnt_reg;
        dir_adv = dir_reg;
        if (per_reg == '0)
        begin
            // zero period parks the counter
            cnt_adv = '0;
            dir_adv = 1'b0;
        end
        else if (!dir_reg)
        begin
            if (cnt_reg >= per_reg)
            begin
                // past the top: turn around just below it
                dir_adv = 1'b1;
                cnt_adv = per_reg - COUNTER_BITS'(1);
            end
            else
            begin
                cnt_adv = cnt_reg + COUNTER_BITS'(1);
                dir_adv = (cnt_adv == per_reg);
            end
        end
        else
        begin
            if (cnt_reg == '0)
            begin
                dir_adv = 1'b0;
                cnt_adv = COUNTER_BITS'(1);
            end
            else
            begin
                cnt_adv = cnt_reg - COUNTER_BITS'(1);
                dir_adv = (cnt_adv != '0);
            end
        end
    end

    // handshake, sequencing and result assembly
    always_comb
    begin
        out_free = !ovalid_reg || !out_stall;
        in_stall = (state_reg == S_RESTART) || (ovalid_reg && out_stall);
        accept   = in_valid && !in_stall;

        state_next = state_reg;
        t_start    = 1'b0;
        t_ack      = 1'b0;
        load       = 1'b0;

        cnt_next   = cnt_reg;
        dir_next   = dir_reg;
        per_next   = per_reg;
        chi_next   = chi_reg;
        clo_next   = clo_reg;
        fault_next = fault_reg;
        nf_next    = nf_reg;

        unique case (state_reg)
            S_RUN:
            begin
                if (accept)
                begin
                    if (restart)
                    begin
                        t_start    = 1'b1;
                        state_next = S_RESTART;
                    end
                    else
                    begin
                        load     = 1'b1;
                        cnt_next = cnt_adv;
                        dir_next = dir_adv;
                    end
                end
            end

            S_RESTART:
            begin
                // new timing set is applied only once the result can leave
                if (t_done && out_free)
                begin
                    t_ack      = 1'b1;
                    load       = 1'b1;
                    cnt_next   = '0;
                    dir_next   = 1'b0;
                    per_next   = t_period;
                    chi_next   = t_hi;
                    clo_next   = t_lo;
                    fault_next = t_fault;
                    nf_next    = t_nf;
                    state_next = S_RUN;
                end
            end

            default:
            begin
                state_next = S_RUN;
            end
        endcase

        // drives follow the counter after this tick
        run        = cfg_reg.drive_enable && (fault_next == FAULT_NONE);
        count_wide = CW_W'(cnt_next);

        hd_next  = run && (cnt_next < chi_next);
        ld_next  = !run || (cnt_next >= clo_next);
        cv_next  = count_wide[COUNT_OUT_W-1:0];
        cd_next  = dir_next;
        fc_next  = fault_next;
        nfo_next = nf_next;

        if (load)
        begin
            ovalid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            ovalid_next = 1'b0;
        end
        else
        begin
            ovalid_next = ovalid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_RUN;
            ovalid_reg <= 1'b0;
            cnt_reg    <= '0;
            dir_reg    <= 1'b0;
            per_reg    <= '0;
            chi_reg    <= '0;
            clo_reg    <= '0;
            fault_reg  <= FAULT_FREQ;
            nf_reg     <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
            cnt_reg    <= cnt_next;
            dir_reg    <= dir_next;
            per_reg    <= per_next;
            chi_reg    <= chi_next;
            clo_reg    <= clo_next;
            fault_reg  <= fault_next;
            nf_reg     <= nf_next;
        end
    end

    // result payload, captured with the item
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            hd_reg  <= hd_next;
            ld_reg  <= ld_next;
            cv_reg  <= cv_next;
            cd_reg  <= cd_next;
            fc_reg  <= fc_next;
            nfo_reg <= nfo_next;
        end
    end

    assign out_valid         = ovalid_reg;
    assign high_drive        = hd_reg;
    assign low_drive         = ld_reg;
    assign count_value       = cv_reg;
    assign counting_down     = cd_reg;
    assign fault_code        = fc_reg;
    assign next_frequency_hz = nfo_reg;

endmodule

>>> rtl/cpd_checker.sv
// cpd_checker: port-level assertions for complementary_pwm_deadtime, bound
// to the top level; depends on cpd_pkg
`timescale 1ns / 1ps

module cpd_checker
    import cpd_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   out_valid,
    input logic                   out_stall,
    input logic                   high_drive,
    input logic                   low_drive,
    input logic [COUNT_OUT_W-1:0] count_value,
    input logic                   counting_down,
    input logic [FAULT_W-1:0]     fault_code,
    input logic [FREQ_W-1:0]      next_frequency_hz
);

    // both switches on would short the bridge
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(high_drive && low_drive))
    else $error("high and low drive active together");

    // a fault leaves the bridge safe
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && fault_code != FAULT_NONE) |-> (!high_drive && low_drive))
    else $error("faulted result does not force low side on");

    // a fault parks the counter and clears the frequency
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && fault_code != FAULT_NONE)
            |-> (count_value == '0 && !counting_down && next_frequency_hz == '0))
    else $error("faulted result shows a running counter or frequency");

    // a waiting result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(count_value)
            && $stable(fault_code) && $stable(high_drive) && $stable(low_drive)))
    else $error("stalled result changed");

endmodule

bind complementary_pwm_deadtime cpd_checker u_cpd_checker (.*);
